// ===== hdl/bbox_longest_axis_shell_sort_macros.svh =====
// Assertion macros used by the box sort controller.
// Depends on nothing; include once per asserting file.
`ifndef BBOX_LONGEST_AXIS_SHELL_SORT_MACROS_SVH
`define BBOX_LONGEST_AXIS_SHELL_SORT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define BLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define BLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/bls_pkg.sv =====
// Shared types and constants of the box sort block.
// Depends on nothing.
package bls_pkg;
  localparam int unsigned CoordW = 16;
  localparam int unsigned KeyW   = 17;
  localparam int unsigned AxisW  = 2;
  localparam logic [AxisW-1:0] AxisX = 2'd0;
  localparam logic [AxisW-1:0] AxisY = 2'd1;
  localparam logic [AxisW-1:0] AxisZ = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // store input word, grow extent
    logic init_ord;   // write identity order at wr_idx_i
    logic pick;       // latch split axis
    logic rd_a;       // read order[j] and order[j+gap]
    logic rd_k;       // read corners of both read entries
    logic swap;       // write swapped pair
    logic rd_out;     // read order at out index
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic greater;    // key[j] > key[j+gap]
  } sts_t;
endpackage

// ===== hdl/bls_datapath.sv =====
// Datapath of the box sort: corner, order memories, extent and compare.
// Depends on bls_pkg.
module bls_datapath #(
  parameter int unsigned MaxBoxes = 32,
  parameter int unsigned IdxW = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bls_pkg::cmd_t              cmd_i,
  input  logic [IdxW-1:0]            wr_idx_i,
  input  logic                       first_i,
  input  logic [IdxW-1:0]            ja_i,
  input  logic [IdxW-1:0]            jb_i,
  input  logic [6*16-1:0]            box_i,
  output bls_pkg::sts_t              sts_o,
  output logic [5:0]                 order_o,
  output logic [bls_pkg::AxisW-1:0]  axis_o
);
  logic [47:0] min_mem [MaxBoxes];
  logic [47:0] max_mem [MaxBoxes];
  logic [IdxW-1:0] ord_mem [MaxBoxes];
  logic signed [15:0] lo_q [3];
  logic signed [15:0] hi_q [3];
  logic [bls_pkg::AxisW-1:0] axis_q;
  logic [IdxW-1:0] oa_q, ob_q;
  logic signed [bls_pkg::KeyW-1:0] ka_q, kb_q;
  logic [47:0] mina_q, maxa_q, minb_q, maxb_q;
  logic signed [16:0] dx, dy, dz;
  logic signed [15:0] in_lo [3];
  logic signed [15:0] in_hi [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      in_lo[a] = box_i[a*16 +: 16];
      in_hi[a] = box_i[(a+3)*16 +: 16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      min_mem[wr_idx_i] <= box_i[47:0];
      max_mem[wr_idx_i] <= box_i[95:48];
    end
    if (cmd_i.init_ord) ord_mem[wr_idx_i] <= wr_idx_i;
    if (cmd_i.swap) begin
      ord_mem[ja_i] <= ob_q;
      ord_mem[jb_i] <= oa_q;
    end
    if (cmd_i.rd_a) begin
      oa_q <= ord_mem[ja_i];
      ob_q <= ord_mem[jb_i];
    end
    if (cmd_i.rd_out) order_o <= 6'(ord_mem[ja_i]);
  end

  // corner reads by the order entries just fetched
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_k) begin
      mina_q <= min_mem[oa_q];
      maxa_q <= max_mem[oa_q];
      minb_q <= min_mem[ob_q];
      maxb_q <= max_mem[ob_q];
    end
  end

  function automatic logic signed [16:0] key_f(input logic [47:0] mn, input logic [47:0] mx,
                                               input logic [1:0] ax);
    logic signed [15:0] p, q;
    begin
      case (ax)
        bls_pkg::AxisY: begin p = mn[31:16]; q = mx[31:16]; end
        bls_pkg::AxisZ: begin p = mn[47:32]; q = mx[47:32]; end
        default:        begin p = mn[15:0];  q = mx[15:0];  end
      endcase
      key_f = 17'(p) + 17'(q);
    end
  endfunction

  always_ff @(posedge clk_i) begin
    ka_q <= key_f(mina_q, maxa_q, axis_q);
    kb_q <= key_f(minb_q, maxb_q, axis_q);
  end
  assign sts_o.greater = ka_q > kb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        lo_q[a] <= '0;
        hi_q[a] <= '0;
      end
      axis_q <= bls_pkg::AxisX;
    end else begin
      if (cmd_i.load) begin
        for (int a = 0; a < 3; a++) begin
          if (first_i || in_lo[a] < lo_q[a]) lo_q[a] <= in_lo[a];
          if (first_i || in_hi[a] > hi_q[a]) hi_q[a] <= in_hi[a];
        end
      end
      if (cmd_i.pick) begin
        if (dz > dx && dz > dy) axis_q <= bls_pkg::AxisZ;
        else if (dy > dx)       axis_q <= bls_pkg::AxisY;
        else                    axis_q <= bls_pkg::AxisX;
      end
    end
  end
  assign dx = 17'(hi_q[0]) - 17'(lo_q[0]);
  assign dy = 17'(hi_q[1]) - 17'(lo_q[1]);
  assign dz = 17'(hi_q[2]) - 17'(lo_q[2]);
  assign axis_o = axis_q;
endmodule

// ===== hdl/bls_ctrl.sv =====
// Controller of the box sort: load, Shell sort sequencing and output.
// Depends on bls_pkg and the assertion macro header.
`include "bbox_longest_axis_shell_sort_macros.svh"
module bls_ctrl #(
  parameter int unsigned MaxBoxes = 32,
  parameter int unsigned IdxW = 5,
  parameter int unsigned CntW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output logic            out_last_o,
  input  logic            out_ready_i,
  input  bls_pkg::sts_t   sts_i,
  output bls_pkg::cmd_t   cmd_o,
  output logic [IdxW-1:0] wr_idx_o,
  output logic            first_o,
  output logic [IdxW-1:0] ja_o,
  output logic [IdxW-1:0] jb_o
);
  localparam logic [3:0] StLoad = 4'd0, StInit = 4'd1, StPick = 4'd2, StGap = 4'd3,
    StRdA = 4'd4, StRdK = 4'd5, StKey = 4'd6, StCmp = 4'd7, StSwap = 4'd8,
    StNext = 4'd9, StRdO = 4'd10, StOut = 4'd11;

  logic [3:0] st_q, st_d;
  logic [CntW-1:0] n_q, n_d, gap_q, gap_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic acc, full;

  assign full = n_q == CntW'(MaxBoxes);
  assign in_ready_o = st_q == StLoad;
  assign acc = in_valid_i && in_ready_o;
  assign out_valid_o = st_q == StOut;
  assign out_last_o = k_q + 1'b1 == n_q;
  assign wr_idx_o = st_q == StInit ? IdxW'(k_q) : IdxW'(n_q);
  assign first_o = n_q == '0;
  assign ja_o = (st_q == StRdO) ? IdxW'(k_q) : IdxW'(j_q);
  assign jb_o = IdxW'(j_q + gap_q);

  always_comb begin
    st_d = st_q; n_d = n_q; gap_d = gap_q; i_d = i_q; j_d = j_q; k_d = k_q;
    cmd_o = '0;
    unique case (st_q)
      StLoad: if (acc) begin
        if (!full) begin
          cmd_o.load = 1'b1;
          n_d = n_q + 1'b1;
        end
        if (in_last_i) begin
          k_d = '0;
          st_d = StInit;
        end
      end
      StInit: begin
        if (k_q == n_q) st_d = StPick;
        else begin
          cmd_o.init_ord = 1'b1;
          k_d = k_q + 1'b1;
        end
      end
      StPick: begin
        cmd_o.pick = 1'b1;
        gap_d = n_q >> 1;
        i_d = n_q >> 1;
        st_d = StGap;
      end
      StGap: begin
        if (gap_q == '0) begin
          k_d = '0;
          st_d = StRdO;
        end else if (i_q >= n_q) begin
          gap_d = gap_q >> 1;
          i_d = gap_q >> 1;
        end else begin
          j_d = i_q - gap_q;
          st_d = StRdA;
        end
      end
      StRdA: begin cmd_o.rd_a = 1'b1; st_d = StRdK; end
      StRdK: begin cmd_o.rd_k = 1'b1; st_d = StKey; end
      StKey: st_d = StCmp;
      StCmp: st_d = sts_i.greater ? StSwap : StNext;
      StSwap: begin
        cmd_o.swap = 1'b1;
        if (j_q < gap_q) st_d = StNext;
        else begin
          j_d = j_q - gap_q;
          st_d = StRdA;
        end
      end
      StNext: begin i_d = i_q + 1'b1; st_d = StGap; end
      StRdO: begin
        if (k_q == n_q) begin
          n_d = '0;
          st_d = StLoad;
        end else begin
          cmd_o.rd_out = 1'b1;
          st_d = StOut;
        end
      end
      StOut: if (out_ready_i) begin
        k_d = k_q + 1'b1;
        st_d = StRdO;
      end
      default: st_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; n_q <= '0; gap_q <= '0; i_q <= '0; j_q <= '0; k_q <= '0;
    end else begin
      st_q <= st_d; n_q <= n_d; gap_q <= gap_d; i_q <= i_d; j_q <= j_d; k_q <= k_d;
    end
  end

  `BLS_ASSERT_IMP(a_cnt_max, clk_i, rst_ni, 1'b1, n_q <= CntW'(MaxBoxes))
  `BLS_ASSERT_IMP(a_out_in_range, clk_i, rst_ni, out_valid_o, k_q < n_q)
  `BLS_ASSERT_IMP(a_swap_bound, clk_i, rst_ni, cmd_o.swap, j_q + gap_q < n_q)
  `BLS_ASSERT_NEXT(a_done_clears, clk_i, rst_ni, out_valid_o && out_ready_i && out_last_o,
    !out_valid_o)
endmodule

// ===== hdl/bbox_longest_axis_shell_sort.sv =====
// Box sort: loads a run of boxes, picks the longest axis, Shell-sorts indices.
// Boxes are taken one per cycle in the load phase; after the last box the order
// memory is set to identity and the split axis picked, then the Shell sort runs
// its compare-swap steps, then each index is read back and emitted. Sort time is
// set by the single order memory read/swap loop. One run is processed at a time.
// Reset (rst_ni low, async) empties the run and clears the enclosing box; stored corners are not cleared.
module bbox_longest_axis_shell_sort #(
  parameter int unsigned MaxBoxes = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // min_x, min_y, min_z, max_x, max_y, max_z
  input  logic         s_axis_tlast,  // last_box
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,  // box_index[5:0], split_axis[7:6]
  output logic         m_axis_tlast   // last_index
);
  localparam int unsigned IdxW = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
  localparam int unsigned CntW = $clog2(MaxBoxes + 1) + 1;

  bls_pkg::cmd_t cmd;
  bls_pkg::sts_t sts;
  logic [IdxW-1:0] wr_idx, ja, jb;
  logic first;
  logic [5:0] order;
  logic [bls_pkg::AxisW-1:0] axis;

  bls_ctrl #(.MaxBoxes(MaxBoxes), .IdxW(IdxW), .CntW(CntW)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_last_i(s_axis_tlast), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_last_o(m_axis_tlast), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd), .wr_idx_o(wr_idx), .first_o(first), .ja_o(ja), .jb_o(jb)
  );

  bls_datapath #(.MaxBoxes(MaxBoxes), .IdxW(IdxW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .wr_idx_i(wr_idx), .first_i(first),
    .ja_i(ja), .jb_i(jb), .box_i(s_axis_tdata), .sts_o(sts), .order_o(order), .axis_o(axis)
  );

  assign m_axis_tdata = {axis, order};
endmodule
